[sv/pdbr_pkg.sv]
// Shared types and constants for the path distance breadcrumb recorder.
// No dependencies; used by the recorder top level and by its checker.
package pdbr_pkg;

   // Default sizing, handed to the top level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int COORD_BITS_DEF = 24;

   // Fixed field widths
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int LIMIT_W   = 7;
   localparam int SPACING_W = 24;
   localparam int ACCUM_W   = 32;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd256;
   // Last-sent index when nothing has been sent (-1)
   localparam logic [CNT_W-1:0]     SENT_NONE     = 7'h7F;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_READ   = 2'd1,
      OP_MARK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SUM,
      ST_ROOT,
      ST_DECIDE,
      ST_RESP,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

endpackage

[sv/pdbr_isqrt.sv]
// Iterative integer square root, one root bit per clock (restoring method).
// Depends on nothing outside itself; instantiated by the recorder top level.
module pdbr_isqrt #(
   parameter int RAD_W = 50
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_W-1:0]     radicand,
   output logic                 done,
   output logic [RAD_W/2-1:0]   root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ROOT_W+1:0] rem_sh;
   logic [ROOT_W+1:0] trial;
   logic              fits;

   // Bring down the next two radicand bits and try a one for this root bit
   always_comb begin
      rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial  = {root_ff, 2'b01};
      fits   = (rem_sh >= trial);
   end

   // Control: busy for ROOT_W steps, then pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // Datapath: shift radicand, update remainder and root
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[sv/path_distance_breadcrumb_recorder.sv]
// Path distance breadcrumb recorder: top level with crumb memory and sequencer.
// Depends on pdbr_pkg and pdbr_isqrt.
//
// One transaction is handled at a time; req_ready is high only while the
// sequencer is idle, but a finished result may still wait in the output
// register while the next transaction is taken. A position update steps
// through difference, squares, sum, square root and decision; the square
// root unit resolves one bit of the step length per cycle. The first update
// after reset or clear skips the distance. A read makes, per returned crumb,
// a synchronous memory read and then loads the output register. Mark, clear
// and a read that returns nothing go straight to the response. Output stalls
// hold the sequencer.
// The crumb memory needs no clearing pass: only entries below the stored
// count are read, and those were written.
module path_distance_breadcrumb_recorder #(
   parameter int CAPACITY   = pdbr_pkg::CAPACITY_DEF,
   parameter int COORD_BITS = pdbr_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic signed [COORD_BITS-1:0]     req_pos_x,
   input  logic signed [COORD_BITS-1:0]     req_pos_y,
   input  logic [pdbr_pkg::IDX_W-1:0]       req_crumb_idx,
   input  logic [pdbr_pkg::LIMIT_W-1:0]     req_read_limit,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [COORD_BITS-1:0]     rsp_out_x,
   output logic signed [COORD_BITS-1:0]     rsp_out_y,
   output logic                             rsp_out_valid,
   output logic [pdbr_pkg::IDX_W-1:0]       rsp_out_index,
   output logic                             rsp_dropped,
   output logic [pdbr_pkg::CNT_W-1:0]       rsp_stored_count,
   output logic signed [pdbr_pkg::CNT_W-1:0] rsp_sent_index,
   output logic                             rsp_last,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [pdbr_pkg::SPACING_W-1:0]   csr_wr_data
);

   localparam int C      = COORD_BITS;
   localparam int CNT_W  = pdbr_pkg::CNT_W;
   localparam int IDX_W  = pdbr_pkg::IDX_W;
   localparam int ACC_W  = pdbr_pkg::ACCUM_W;
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SUM_W  = 2 * C + 1;
   localparam int SQ_W   = (SUM_W > 64) ? 64 : SUM_W;
   localparam int RAD_W  = SQ_W + (SQ_W % 2);
   localparam int ROOT_W = RAD_W / 2;

   pdbr_pkg::state_type state_ff, state_in;
   pdbr_pkg::op_type    op_in;

   logic signed [C-1:0] x_ff, y_ff;
   logic signed [C-1:0] prev_x_ff, prev_y_ff;
   logic                have_prev_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    sent_ff;
   logic [ACC_W-1:0]    accum_ff;
   logic [pdbr_pkg::SPACING_W-1:0] spacing_ff;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    remain_ff;
   logic                crumb_ff;
   logic [C-1:0]        mag_x_ff, mag_y_ff;
   logic [2*C-1:0]      sq_x_ff, sq_y_ff;
   logic [2*C-1:0]      rd_ff;

   logic [2*C-1:0]      crumb_mem [CAPACITY];

   logic                accept;
   logic                slot_free;
   logic                rd_empty;
   logic [CNT_W-1:0]    rd_avail;
   logic [CNT_W-1:0]    rd_count;
   logic                mark_ok;
   logic signed [C:0]   dx, dy;
   logic [C-1:0]        mult_a;
   logic [2*C-1:0]      product;
   logic [SUM_W-1:0]    sum_full;
   logic [RAD_W-1:0]    radicand;
   logic                root_start;
   logic                root_done;
   logic [ROOT_W-1:0]   root;
   logic [ACC_W:0]      acc_sum;
   logic                drop_now;
   logic                mem_re;
   logic                load_resp;
   logic                load_rd;

   assign op_in     = pdbr_pkg::op_type'(req_operation);
   assign req_ready = (state_ff == pdbr_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid || rsp_ready;

   // Read window: start must lie below the count and the limit be nonzero
   always_comb begin
      rd_empty = ({1'b0, req_crumb_idx} >= count_ff) || (req_read_limit == '0);
      rd_avail = count_ff - {1'b0, req_crumb_idx};
      rd_count = (req_read_limit < rd_avail) ? req_read_limit : rd_avail;
      mark_ok  = ($signed({1'b0, req_crumb_idx}) > $signed(sent_ff))
                 && ({1'b0, req_crumb_idx} < count_ff);
   end

   // Step deltas, one shared squarer
   always_comb begin
      dx      = {x_ff[C-1], x_ff} - {prev_x_ff[C-1], prev_x_ff};
      dy      = {y_ff[C-1], y_ff} - {prev_y_ff[C-1], prev_y_ff};
      mult_a  = (state_ff == pdbr_pkg::ST_SQ_X) ? mag_x_ff : mag_y_ff;
      product = mult_a * mult_a;
      sum_full = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   // Clamp the squared sum to 64 bits where it can grow past them
   if (SUM_W > 64) begin : g_sat
      assign radicand = (|sum_full[SUM_W-1:64]) ? '1 : sum_full[63:0];
   end else begin : g_nosat
      assign radicand = RAD_W'(sum_full);
   end

   pdbr_isqrt #(
      .RAD_W (RAD_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   assign acc_sum = {1'b0, accum_ff} + (ACC_W + 1)'(root);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdbr_pkg::ST_IDLE: begin
            if (accept) begin
               case (op_in)
                  pdbr_pkg::OP_UPDATE:
                     state_in = have_prev_ff ? pdbr_pkg::ST_DIFF : pdbr_pkg::ST_DECIDE;
                  pdbr_pkg::OP_READ:
                     state_in = rd_empty ? pdbr_pkg::ST_RESP : pdbr_pkg::ST_RD_ADDR;
                  default:
                     state_in = pdbr_pkg::ST_RESP;
               endcase
            end
         end
         pdbr_pkg::ST_DIFF:   state_in = pdbr_pkg::ST_SQ_X;
         pdbr_pkg::ST_SQ_X:   state_in = pdbr_pkg::ST_SQ_Y;
         pdbr_pkg::ST_SQ_Y:   state_in = pdbr_pkg::ST_SUM;
         pdbr_pkg::ST_SUM:    state_in = pdbr_pkg::ST_ROOT;
         pdbr_pkg::ST_ROOT: begin
            if (root_done) state_in = pdbr_pkg::ST_DECIDE;
         end
         pdbr_pkg::ST_DECIDE: state_in = pdbr_pkg::ST_RESP;
         pdbr_pkg::ST_RESP: begin
            if (slot_free) state_in = pdbr_pkg::ST_IDLE;
         end
         pdbr_pkg::ST_RD_ADDR: state_in = pdbr_pkg::ST_RD_DATA;
         pdbr_pkg::ST_RD_DATA: begin
            if (slot_free) begin
               state_in = (remain_ff == CNT_W'(1)) ? pdbr_pkg::ST_IDLE
                                                   : pdbr_pkg::ST_RD_ADDR;
            end
         end
         default: state_in = pdbr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      root_start = (state_ff == pdbr_pkg::ST_SUM);
      mem_re     = (state_ff == pdbr_pkg::ST_RD_ADDR);
      drop_now   = (state_ff == pdbr_pkg::ST_DECIDE)
                   && (accum_ff >= ACC_W'(spacing_ff))
                   && (count_ff < CNT_W'(CAPACITY));
      load_resp  = (state_ff == pdbr_pkg::ST_RESP) && slot_free;
      load_rd    = (state_ff == pdbr_pkg::ST_RD_DATA) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pdbr_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Spacing register
   always_ff @(posedge clock) begin
      if (reset)          spacing_ff <= pdbr_pkg::SPACING_RESET;
      else if (csr_wr_en) spacing_ff <= csr_wr_data;
   end

   // Trail state: count, last-sent index, accumulator, previous-fix flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sent_ff      <= pdbr_pkg::SENT_NONE;
         accum_ff     <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (accept && op_in == pdbr_pkg::OP_CLEAR) begin
            count_ff     <= '0;
            sent_ff      <= pdbr_pkg::SENT_NONE;
            accum_ff     <= '0;
            have_prev_ff <= 1'b0;
         end
         if (accept && op_in == pdbr_pkg::OP_MARK && mark_ok) begin
            sent_ff <= {1'b0, req_crumb_idx};
         end
         if (state_ff == pdbr_pkg::ST_ROOT && root_done) begin
            accum_ff <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
         end
         if (state_ff == pdbr_pkg::ST_DECIDE) begin
            have_prev_ff <= 1'b1;
         end
         if (drop_now) begin
            count_ff <= count_ff + CNT_W'(1);
            accum_ff <= '0;
         end
      end
   end

   // Transaction payload, step magnitudes and squares
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         crumb_ff <= 1'b0;
         ptr_ff   <= {1'b0, req_crumb_idx};
         remain_ff <= rd_count;
      end
      if (state_ff == pdbr_pkg::ST_DIFF) begin
         mag_x_ff <= dx[C] ? C'(-dx) : dx[C-1:0];
         mag_y_ff <= dy[C] ? C'(-dy) : dy[C-1:0];
      end
      if (state_ff == pdbr_pkg::ST_SQ_X) sq_x_ff <= product;
      if (state_ff == pdbr_pkg::ST_SQ_Y) sq_y_ff <= product;
      if (state_ff == pdbr_pkg::ST_DECIDE) begin
         prev_x_ff <= x_ff;
         prev_y_ff <= y_ff;
      end
      if (drop_now) begin
         crumb_ff <= 1'b1;
         ptr_ff   <= count_ff;
      end
      if (load_rd) begin
         ptr_ff    <= ptr_ff + CNT_W'(1);
         remain_ff <= remain_ff - CNT_W'(1);
      end
   end

   // Crumb memory: write on drop, registered read during a stream
   always_ff @(posedge clock) begin
      if (drop_now) crumb_mem[count_ff[ADDR_W-1:0]] <= {x_ff, y_ff};
      if (mem_re)   rd_ff <= crumb_mem[ptr_ff[ADDR_W-1:0]];
   end

   // Output register: load a result when the slot is free, drop it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (load_resp || load_rd) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_resp) begin
         rsp_out_x        <= crumb_ff ? x_ff : '0;
         rsp_out_y        <= crumb_ff ? y_ff : '0;
         rsp_out_valid    <= crumb_ff;
         rsp_out_index    <= crumb_ff ? ptr_ff[IDX_W-1:0] : '0;
         rsp_dropped      <= crumb_ff;
         rsp_stored_count <= count_ff;
         rsp_sent_index   <= sent_ff;
         rsp_last         <= 1'b1;
      end else if (load_rd) begin
         rsp_out_x        <= rd_ff[2*C-1:C];
         rsp_out_y        <= rd_ff[C-1:0];
         rsp_out_valid    <= 1'b1;
         rsp_out_index    <= ptr_ff[IDX_W-1:0];
         rsp_dropped      <= 1'b0;
         rsp_stored_count <= count_ff;
         rsp_sent_index   <= sent_ff;
         rsp_last         <= (remain_ff == CNT_W'(1));
      end
   end

endmodule

[sv/pdbr_checker.sv]
// Port-level checks for the path distance breadcrumb recorder, bound to it.
// Depends on pdbr_pkg; sees only the top level's ports.
module pdbr_checker #(
   parameter int CAPACITY   = pdbr_pkg::CAPACITY_DEF,
   parameter int COORD_BITS = pdbr_pkg::COORD_BITS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [COORD_BITS-1:0]      rsp_out_x,
   input logic signed [COORD_BITS-1:0]      rsp_out_y,
   input logic                              rsp_out_valid,
   input logic [pdbr_pkg::IDX_W-1:0]        rsp_out_index,
   input logic                              rsp_dropped,
   input logic [pdbr_pkg::CNT_W-1:0]        rsp_stored_count,
   input logic signed [pdbr_pkg::CNT_W-1:0] rsp_sent_index,
   input logic                              rsp_last
);

   localparam int CNT_W = pdbr_pkg::CNT_W;

   // Hold the coordinates, index and last flag of a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_index) && $stable(rsp_last))
      else $error("response changed while stalled");

   // A drop always carries its crumb and ends the transaction
   a_drop_crumb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_out_valid && rsp_last)
      else $error("dropped result without crumb or not last");

   // A result without a crumb is final and all zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_last && !rsp_dropped
         && rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_index == '0)
      else $error("empty result carries data");

   // Count stays within capacity and the sent index below the count
   a_count_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stored_count <= CNT_W'(CAPACITY)
         && rsp_sent_index < $signed({1'b0, rsp_stored_count}))
      else $error("count or sent index out of range");

   // A returned crumb lies below the count
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> {1'b0, rsp_out_index} < rsp_stored_count)
      else $error("crumb index beyond count");

endmodule

bind path_distance_breadcrumb_recorder pdbr_checker #(
   .CAPACITY   (CAPACITY),
   .COORD_BITS (COORD_BITS)
) u_pdbr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_x        (rsp_out_x),
   .rsp_out_y        (rsp_out_y),
   .rsp_out_valid    (rsp_out_valid),
   .rsp_out_index    (rsp_out_index),
   .rsp_dropped      (rsp_dropped),
   .rsp_stored_count (rsp_stored_count),
   .rsp_sent_index   (rsp_sent_index),
   .rsp_last         (rsp_last)
);
